// File: src/lpc_pkg.sv
`default_nettype none
package lpc_pkg;
  localparam int POOL_FRAMES = 16;
  localparam int PAGE_ID_BITS = 32;
  localparam int PIN_BITS = 16;

  localparam logic [2:0] ACT_FETCH = 3'd0;
  localparam logic [2:0] ACT_NEW = 3'd1;
  localparam logic [2:0] ACT_UNPIN = 3'd2;
  localparam logic [2:0] ACT_FLUSH = 3'd3;
  localparam logic [2:0] ACT_FLUSH_ALL = 3'd4;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_LOADED = 3'd1;
  localparam logic [2:0] ST_PINNED = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [1:0] ADDR_FRAMES_IN_USE = 2'd0;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_FLUSH, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat, clear scan state
    logic scan;      // examine current frame, advance index
    logic apply;     // commit single-item operation and emit result
    logic flush_one; // flush-all: act on current frame
    logic flush_end; // flush-all closing beat
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic is_flush_all;
  } stat_t;
endpackage
`default_nettype wire

// File: src/lpc_datapath.sv
`default_nettype none
module lpc_datapath #(
  parameter int POOL_FRAMES = lpc_pkg::POOL_FRAMES,
  parameter int PAGE_ID_BITS = lpc_pkg::PAGE_ID_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire lpc_pkg::cmd_t           cmd,
  output lpc_pkg::stat_t               stat,
  input  wire logic [2:0]              action,
  input  wire logic [PAGE_ID_BITS-1:0] page_id,
  input  wire logic                    mark_dirty,
  input  wire logic [4:0]              frames_in_use,
  output logic                         strobe,
  output logic [2:0]                   status,
  output logic [3:0]                   frame_index,
  output logic                         read_needed,
  output logic                         write_back,
  output logic [PAGE_ID_BITS-1:0]      write_page_id,
  output logic                         evicted,
  output logic [15:0]                  pins_now,
  output logic [4:0]                   cached_count,
  output logic                         disk_sync,
  output logic                         last
);
  localparam int IW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int CW = $clog2(POOL_FRAMES + 1);
  localparam int RW = IW;
  localparam logic [15:0] PIN_MAX = 16'hFFFF;

  logic [POOL_FRAMES-1:0]  fvalid;
  logic [POOL_FRAMES-1:0]  fdirty;
  logic [PAGE_ID_BITS-1:0] fpage [POOL_FRAMES];
  logic [15:0]             fpins [POOL_FRAMES];
  logic [RW-1:0]           frank [POOL_FRAMES];
  logic [CW-1:0]           count;

  logic [2:0]              act;
  logic [PAGE_ID_BITS-1:0] pid;
  logic                    mdirty;
  logic [IW-1:0]           idx;
  logic                    hit_found, free_found, vic_found;
  logic [IW-1:0]           hit_idx, free_idx, vic_idx;

  logic [CW-1:0] limit;
  always_comb begin
    if (frames_in_use == 5'd0) limit = CW'(1);
    else if (32'(frames_in_use) > POOL_FRAMES) limit = CW'(POOL_FRAMES);
    else limit = CW'(frames_in_use);
  end

  assign stat.scan_last = (32'(idx) == POOL_FRAMES - 1);
  assign stat.is_flush_all = (act == lpc_pkg::ACT_FLUSH_ALL);

  logic need_evict, load_act;
  assign need_evict = (count >= limit);
  assign load_act = (act == lpc_pkg::ACT_FETCH) || (act == lpc_pkg::ACT_NEW);

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      fvalid <= '0;
      fdirty <= '0;
      count <= '0;
      idx <= '0;
    end else begin
      if (cmd.load) begin
        act <= action;
        pid <= page_id;
        mdirty <= mark_dirty;
        idx <= '0;
        hit_found <= 1'b0;
        free_found <= 1'b0;
        vic_found <= 1'b0;
      end
      if (cmd.scan) begin
        if (fvalid[idx] && fpage[idx] == pid && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx <= idx;
        end
        if (!fvalid[idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx <= idx;
        end
        if (fvalid[idx] && fpins[idx] == 16'd0 &&
            (!vic_found || frank[idx] > frank[vic_idx])) begin
          vic_found <= 1'b1;
          vic_idx <= idx;
        end
        if (!stat.scan_last) idx <= idx + IW'(1);
      end
      if (cmd.flush_one) begin
        if (fvalid[idx] && fdirty[idx]) begin
          fdirty[idx] <= 1'b0;
          strobe <= 1'b1;
          status <= lpc_pkg::ST_DONE;
          frame_index <= 4'(idx);
          read_needed <= 1'b0;
          write_back <= 1'b1;
          write_page_id <= fpage[idx];
          evicted <= 1'b0;
          pins_now <= fpins[idx];
          cached_count <= 5'(count);
          disk_sync <= 1'b0;
          last <= 1'b0;
        end
        if (!stat.scan_last) idx <= idx + IW'(1);
      end
      if (cmd.flush_end) begin
        strobe <= 1'b1;
        status <= lpc_pkg::ST_DONE;
        frame_index <= '0;
        read_needed <= 1'b0;
        write_back <= 1'b0;
        write_page_id <= '0;
        evicted <= 1'b0;
        pins_now <= '0;
        cached_count <= 5'(count);
        disk_sync <= 1'b1;
        last <= 1'b1;
      end
      if (cmd.apply) begin
        strobe <= 1'b1;
        status <= lpc_pkg::ST_IGNORED;
        frame_index <= '0;
        read_needed <= 1'b0;
        write_back <= 1'b0;
        write_page_id <= '0;
        evicted <= 1'b0;
        pins_now <= '0;
        cached_count <= 5'(count);
        disk_sync <= 1'b0;
        last <= 1'b1;
        if (load_act && hit_found) begin
          status <= lpc_pkg::ST_HIT;
          frame_index <= 4'(hit_idx);
          pins_now <= (fpins[hit_idx] < PIN_MAX) ? fpins[hit_idx] + 16'd1 : PIN_MAX;
          if (fpins[hit_idx] < PIN_MAX) fpins[hit_idx] <= fpins[hit_idx] + 16'd1;
          for (int i = 0; i < POOL_FRAMES; i++) begin
            if (fvalid[i] && IW'(i) != hit_idx && frank[i] < frank[hit_idx])
              frank[i] <= frank[i] + RW'(1);
          end
          frank[hit_idx] <= '0;
        end else if (load_act && need_evict && !vic_found) begin
          status <= lpc_pkg::ST_PINNED;
        end else if (load_act && need_evict) begin
          // evict victim and reuse its slot (lowest free after eviction)
          status <= lpc_pkg::ST_LOADED;
          read_needed <= (act == lpc_pkg::ACT_FETCH);
          write_back <= fdirty[vic_idx];
          write_page_id <= fpage[vic_idx];
          evicted <= 1'b1;
          pins_now <= 16'd1;
          if (free_found && free_idx < vic_idx) begin
            frame_index <= 4'(free_idx);
            fvalid[vic_idx] <= 1'b0;
            fvalid[free_idx] <= 1'b1;
            fdirty[free_idx] <= 1'b0;
            fdirty[vic_idx] <= 1'b0;
            fpage[free_idx] <= pid;
            fpins[free_idx] <= 16'd1;
            frank[free_idx] <= '0;
          end else begin
            frame_index <= 4'(vic_idx);
            fdirty[vic_idx] <= 1'b0;
            fpage[vic_idx] <= pid;
            fpins[vic_idx] <= 16'd1;
            frank[vic_idx] <= '0;
          end
          for (int i = 0; i < POOL_FRAMES; i++) begin
            if (fvalid[i] && IW'(i) != vic_idx)
              frank[i] <= (frank[i] > frank[vic_idx]) ? frank[i] : frank[i] + RW'(1);
          end
        end else if (load_act) begin
          status <= lpc_pkg::ST_LOADED;
          read_needed <= (act == lpc_pkg::ACT_FETCH);
          write_page_id <= '0;
          pins_now <= 16'd1;
          frame_index <= 4'(free_idx);
          cached_count <= 5'(count + CW'(1));
          count <= count + CW'(1);
          fvalid[free_idx] <= 1'b1;
          fdirty[free_idx] <= 1'b0;
          fpage[free_idx] <= pid;
          fpins[free_idx] <= 16'd1;
          frank[free_idx] <= '0;
          for (int i = 0; i < POOL_FRAMES; i++) begin
            if (fvalid[i]) frank[i] <= frank[i] + RW'(1);
          end
        end else if (act == lpc_pkg::ACT_UNPIN && hit_found) begin
          frame_index <= 4'(hit_idx);
          if (fpins[hit_idx] != 16'd0) begin
            status <= lpc_pkg::ST_DONE;
            pins_now <= fpins[hit_idx] - 16'd1;
            fpins[hit_idx] <= fpins[hit_idx] - 16'd1;
            if (mdirty) fdirty[hit_idx] <= 1'b1;
            for (int i = 0; i < POOL_FRAMES; i++) begin
              if (fvalid[i] && IW'(i) != hit_idx && frank[i] < frank[hit_idx])
                frank[i] <= frank[i] + RW'(1);
            end
            frank[hit_idx] <= '0;
          end
        end else if (act == lpc_pkg::ACT_FLUSH && hit_found) begin
          status <= lpc_pkg::ST_DONE;
          frame_index <= 4'(hit_idx);
          write_back <= fdirty[hit_idx];
          write_page_id <= pid;
          pins_now <= fpins[hit_idx];
          fdirty[hit_idx] <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: src/lpc_ctrl.sv
`default_nettype none
module lpc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire lpc_pkg::stat_t stat,
  output lpc_pkg::cmd_t       cmd
);
  lpc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= lpc_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != lpc_pkg::S_IDLE);
    case (state)
      lpc_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = lpc_pkg::S_SCAN;
        end
      end
      lpc_pkg::S_SCAN: begin
        if (stat.is_flush_all) begin
          state_next = lpc_pkg::S_FLUSH;
        end else begin
          cmd.scan = 1'b1;
          if (stat.scan_last) state_next = lpc_pkg::S_DECIDE;
        end
      end
      lpc_pkg::S_DECIDE: begin
        cmd.apply = 1'b1;
        state_next = lpc_pkg::S_DONE;
      end
      lpc_pkg::S_FLUSH: begin
        cmd.flush_one = 1'b1;
        if (stat.scan_last) state_next = lpc_pkg::S_DONE;
      end
      lpc_pkg::S_DONE: begin
        if (stat.is_flush_all) cmd.flush_end = 1'b1;
        state_next = lpc_pkg::S_IDLE;
      end
      default: state_next = lpc_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: src/lru_pinned_page_cache.sv
`default_nettype none
// channel  | signals                                   | handshake
// cfg      | psel penable pwrite paddr pwdata prdata   | APB, pready always high
// in       | action page_id mark_dirty                 | start && !busy
// out      | status .. last                            | strobe, one cycle, no stall
// An item runs from accept to next accept through the scan, one frame per cycle,
// then the commit state (S_DECIDE), the closing state (S_DONE) and back to idle.
// Flush-all passes through a dispatch state, emits one beat per dirty frame during its scan,
// then the closing beat once the controller is back in idle.
// Reset clears valid and dirty bits and sets frames_in_use to 16.
module lru_pinned_page_cache #(
  parameter int POOL_FRAMES = lpc_pkg::POOL_FRAMES,
  parameter int PAGE_ID_BITS = lpc_pkg::PAGE_ID_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [1:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              action,
  input  wire logic [PAGE_ID_BITS-1:0] page_id,
  input  wire logic                    mark_dirty,
  output logic                         strobe,
  output logic [2:0]                   status,
  output logic [3:0]                   frame_index,
  output logic                         read_needed,
  output logic                         write_back,
  output logic [PAGE_ID_BITS-1:0]      write_page_id,
  output logic                         evicted,
  output logic [15:0]                  pins_now,
  output logic [4:0]                   cached_count,
  output logic                         disk_sync,
  output logic                         last
);
  logic [4:0] frames_in_use;
  lpc_pkg::cmd_t cmd;
  lpc_pkg::stat_t stat;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) frames_in_use <= 5'd16;
    else if (psel && penable && pwrite && paddr == lpc_pkg::ADDR_FRAMES_IN_USE)
      frames_in_use <= pwdata[4:0];
  end
  assign prdata = (paddr == lpc_pkg::ADDR_FRAMES_IN_USE) ? {27'd0, frames_in_use} : 32'd0;

  lpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  lpc_datapath #(.POOL_FRAMES(POOL_FRAMES), .PAGE_ID_BITS(PAGE_ID_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .action(action), .page_id(page_id), .mark_dirty(mark_dirty),
    .frames_in_use(frames_in_use),
    .strobe(strobe), .status(status), .frame_index(frame_index),
    .read_needed(read_needed), .write_back(write_back),
    .write_page_id(write_page_id), .evicted(evicted), .pins_now(pins_now),
    .cached_count(cached_count), .disk_sync(disk_sync), .last(last)
  );
endmodule
`default_nettype wire

// File: src/lpc_checker.sv
`default_nettype none
module lpc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic       last,
  input wire logic       disk_sync,
  input wire logic [4:0] cached_count
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept without busy");
  a_idle_no_beat: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !strobe) else $error("beat while idle");
  a_sync_last: assert property (@(posedge clk) disable iff (rst)
    strobe && disk_sync |-> last) else $error("sync not last");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> cached_count <= 5'd16) else $error("count range");
endmodule

bind lru_pinned_page_cache lpc_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .last(last), .disk_sync(disk_sync), .cached_count(cached_count)
);
`default_nettype wire

// File: test/tb_lru_pinned_page_cache.sv
`default_nettype none
module tb_lru_pinned_page_cache;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic        read_needed;
    logic        write_back;
    logic [31:0] write_page_id;
    logic        evicted;
    logic [15:0] pins_now;
    logic [4:0]  cached_count;
    logic        disk_sync;
    logic        last;
  } beat_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("ERROR %s", msg);
    errors++;
  endtask

  class cache_scoreboard;
    bit          valid[16];
    bit [31:0]   page[16];
    int unsigned pins[16];
    bit          dirty[16];
    int unsigned rank[16];
    int unsigned limit_reg;
    beat_t       pending[$];

    function void clear();
      foreach (valid[i]) begin
        valid[i] = 0; dirty[i] = 0; page[i] = 0; pins[i] = 0; rank[i] = 0;
      end
      limit_reg = 16;
      pending.delete();
    endfunction

    function int count();
      int n;
      n = 0;
      foreach (valid[i]) if (valid[i]) n++;
      return n;
    endfunction

    function int lookup(bit [31:0] pid);
      for (int i = 0; i < 16; i++) if (valid[i] && page[i] == pid) return i;
      return -1;
    endfunction

    function void to_front(int f);
      int unsigned old;
      old = rank[f];
      for (int i = 0; i < 16; i++) if (valid[i] && i != f && rank[i] < old) rank[i]++;
      rank[f] = 0;
    endfunction

    function void push(logic [2:0] st, int fr, bit rd, bit wb, bit [31:0] wp, bit ev,
                       int unsigned pn, bit sy, bit ls);
      beat_t b;
      b.status = st; b.frame_index = fr[3:0]; b.read_needed = rd; b.write_back = wb;
      b.write_page_id = wp; b.evicted = ev; b.pins_now = pn[15:0];
      b.cached_count = 5'(count()); b.disk_sync = sy; b.last = ls;
      pending.push_back(b);
    endfunction

    function void pin_page(bit [31:0] pid, bit is_new);
      int f, v, lim;
      bit ev, wb;
      bit [31:0] vp;
      f = lookup(pid);
      if (f >= 0) begin
        if (pins[f] < 65535) pins[f]++;
        to_front(f);
        push(lpc_pkg::ST_HIT, f, 0, 0, 0, 0, pins[f], 0, 1);
        return;
      end
      lim = limit_reg == 0 ? 1 : (limit_reg > 16 ? 16 : limit_reg);
      ev = 0; wb = 0; vp = 0;
      if (count() >= lim) begin
        v = -1;
        for (int i = 0; i < 16; i++)
          if (valid[i] && pins[i] == 0 && (v < 0 || rank[i] > rank[v])) v = i;
        if (v < 0) begin
          push(lpc_pkg::ST_PINNED, 0, 0, 0, 0, 0, 0, 0, 1);
          return;
        end
        ev = 1; wb = dirty[v]; vp = page[v];
        for (int i = 0; i < 16; i++) if (valid[i] && i != v && rank[i] > rank[v]) rank[i]--;
        valid[v] = 0; dirty[v] = 0;
      end
      f = -1;
      for (int i = 0; i < 16 && f < 0; i++) if (!valid[i]) f = i;
      for (int i = 0; i < 16; i++) if (valid[i]) rank[i]++;
      valid[f] = 1; page[f] = pid; pins[f] = 1; dirty[f] = 0; rank[f] = 0;
      push(lpc_pkg::ST_LOADED, f, !is_new, wb, vp, ev, 1, 0, 1);
    endfunction

    function void note_input(logic [2:0] act, bit [31:0] pid, bit md);
      int f;
      case (act)
        lpc_pkg::ACT_FETCH: pin_page(pid, 0);
        lpc_pkg::ACT_NEW: pin_page(pid, 1);
        lpc_pkg::ACT_UNPIN: begin
          f = lookup(pid);
          if (f < 0) push(lpc_pkg::ST_IGNORED, 0, 0, 0, 0, 0, 0, 0, 1);
          else if (pins[f] == 0) push(lpc_pkg::ST_IGNORED, f, 0, 0, 0, 0, 0, 0, 1);
          else begin
            pins[f]--;
            if (md) dirty[f] = 1;
            to_front(f);
            push(lpc_pkg::ST_DONE, f, 0, 0, 0, 0, pins[f], 0, 1);
          end
        end
        lpc_pkg::ACT_FLUSH: begin
          f = lookup(pid);
          if (f < 0) push(lpc_pkg::ST_IGNORED, 0, 0, 0, 0, 0, 0, 0, 1);
          else begin
            bit wb;
            wb = dirty[f];
            dirty[f] = 0;
            push(lpc_pkg::ST_DONE, f, 0, wb, pid, 0, pins[f], 0, 1);
          end
        end
        lpc_pkg::ACT_FLUSH_ALL: begin
          for (int i = 0; i < 16; i++)
            if (valid[i] && dirty[i]) begin
              dirty[i] = 0;
              push(lpc_pkg::ST_DONE, i, 0, 1, page[i], 0, pins[i], 0, 0);
            end
          push(lpc_pkg::ST_DONE, 0, 0, 0, 0, 0, 0, 1, 1);
        end
        default: push(lpc_pkg::ST_IGNORED, 0, 0, 0, 0, 0, 0, 0, 1);
      endcase
    endfunction

    task check_beat(beat_t got);
      beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat status=%0d", got.status));
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d exp %0d", got.status, e.status));
      if (got.frame_index !== e.frame_index)
        report($sformatf("frame_index %0d exp %0d", got.frame_index, e.frame_index));
      if (got.read_needed !== e.read_needed)
        report($sformatf("read_needed %0b exp %0b", got.read_needed, e.read_needed));
      if (got.write_back !== e.write_back)
        report($sformatf("write_back %0b exp %0b", got.write_back, e.write_back));
      if (got.write_page_id !== e.write_page_id)
        report($sformatf("write_page_id %h exp %h", got.write_page_id, e.write_page_id));
      if (got.evicted !== e.evicted)
        report($sformatf("evicted %0b exp %0b", got.evicted, e.evicted));
      if (got.pins_now !== e.pins_now)
        report($sformatf("pins_now %0d exp %0d", got.pins_now, e.pins_now));
      if (got.cached_count !== e.cached_count)
        report($sformatf("cached_count %0d exp %0d", got.cached_count, e.cached_count));
      if (got.disk_sync !== e.disk_sync)
        report($sformatf("disk_sync %0b exp %0b", got.disk_sync, e.disk_sync));
      if (got.last !== e.last)
        report($sformatf("last %0b exp %0b", got.last, e.last));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0;
  logic busy;
  logic [2:0] action = 0;
  logic [31:0] page_id = 0;
  logic mark_dirty = 0;
  logic strobe;
  logic [2:0] status;
  logic [3:0] frame_index;
  logic read_needed, write_back, evicted, disk_sync, last;
  logic [31:0] write_page_id;
  logic [15:0] pins_now;
  logic [4:0] cached_count;

  cache_scoreboard sb = new();
  bit [31:0] hot[8];

  lru_pinned_page_cache dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      beat_t b;
      b.status = status; b.frame_index = frame_index; b.read_needed = read_needed;
      b.write_back = write_back; b.write_page_id = write_page_id; b.evicted = evicted;
      b.pins_now = pins_now; b.cached_count = cached_count; b.disk_sync = disk_sync;
      b.last = last;
      sb.check_beat(b);
    end
  end

  // start stays high after the accept; drain drops it, and so does gap when it waits
  task automatic send(input logic [2:0] act, input bit [31:0] pid, input bit md);
    start <= 1; action <= act; page_id <= pid; mark_dirty <= md;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(act, pid, md);
  endtask

  task automatic gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (n != 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_limit(input int unsigned v);
    drain();
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= lpc_pkg::ADDR_FRAMES_IN_USE;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.limit_reg = v & 31;
  endtask

  task automatic random_item();
    int r;
    bit [31:0] pid;
    r = $urandom_range(0, 99);
    pid = ($urandom_range(0, 9) == 0) ? $urandom() : hot[$urandom_range(0, 7)];
    if (r < 35) send(lpc_pkg::ACT_FETCH, pid, 0);
    else if (r < 45) send(lpc_pkg::ACT_NEW, pid, 1'($urandom_range(0, 1)));
    else if (r < 80) send(lpc_pkg::ACT_UNPIN, pid, 1'($urandom_range(0, 1)));
    else if (r < 90) send(lpc_pkg::ACT_FLUSH, pid, 1'($urandom_range(0, 1)));
    else if (r < 96) send(lpc_pkg::ACT_FLUSH_ALL, pid, 0);
    else send(3'($urandom_range(5, 7)), pid, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    sb.clear();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(lpc_pkg::ACT_FETCH, 32'h0, 0);
    send(lpc_pkg::ACT_NEW, 32'hFFFF_FFFF, 1);
    send(lpc_pkg::ACT_FETCH, 32'h0, 0);
    send(lpc_pkg::ACT_UNPIN, 32'h0, 1);
    send(lpc_pkg::ACT_UNPIN, 32'h0, 0);
    send(lpc_pkg::ACT_UNPIN, 32'h0, 0);
    send(lpc_pkg::ACT_UNPIN, 32'h1234, 0);
    send(lpc_pkg::ACT_FLUSH, 32'h0, 0);
    send(lpc_pkg::ACT_FLUSH, 32'h5555_AAAA, 0);
    send(lpc_pkg::ACT_UNPIN, 32'hFFFF_FFFF, 1);
    send(lpc_pkg::ACT_FLUSH_ALL, 0, 0);
    send(3'd5, 32'h0, 1);
    send(3'd7, 32'hFFFF_FFFF, 0);
    set_limit(0);
    send(lpc_pkg::ACT_FETCH, 32'hAAAA_5555, 0);
    send(lpc_pkg::ACT_FETCH, 32'h0000_0001, 0);
    set_limit(2);
    send(lpc_pkg::ACT_UNPIN, 32'hAAAA_5555, 0);
    send(lpc_pkg::ACT_FETCH, 32'h0000_0002, 0);
    send(lpc_pkg::ACT_FLUSH_ALL, 0, 0);
    set_limit(31);
    for (int i = 0; i < 17; i++) send(lpc_pkg::ACT_NEW, 32'h100 + i, 0);
    for (int ph = 0; ph < 6; ph++) begin
      int lim;
      lim = (ph == 0) ? 1 : (ph == 1) ? 16 : (ph == 2) ? 20 : $urandom_range(2, 15);
      set_limit(lim);
      for (int i = 0; i < 8; i++) hot[i] = (ph[0] ? $urandom() : 32'h100 + i);
      for (int i = 0; i < 16; i++) send(lpc_pkg::ACT_UNPIN, 32'h100 + i, 1);
      for (int k = 0; k < 57; k++) begin
        random_item();
        gap();
        if (k == 28) drain();
      end
    end
    drain();
    if (errors == 0) $display("lru_pinned_page_cache verification clean");
    else $display("lru_pinned_page_cache verification failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("lru_pinned_page_cache verification failed");
    $finish;
  end
endmodule
`default_nettype wire
